FILE: rtl/ctwl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctwl_pkg: connection table lookup types and constants
// Shared item formats, mode and status codes, and the per-cell entry record.
// ----------------------------------------------------------------------------
package ctwl_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int ID_W            = 4;
   localparam int ADDR_W          = 32;
   localparam int PORT_W          = 16;

   typedef enum logic [2:0] {
      MODE_INSERT    = 3'd0,
      MODE_REMOVE_ID = 3'd1,
      MODE_REMOVE_HD = 3'd2,
      MODE_FIND_ID   = 3'd3,
      MODE_EXACT     = 3'd4,
      MODE_WILD      = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CTL_IDLE = 2'd0,
      CTL_LOOK = 2'd1,
      CTL_PICK = 2'd2
   } ctl_state_type;

   typedef struct packed {
      logic [2:0]        mode;
      logic [ID_W-1:0]   entry_id;
      logic [ADDR_W-1:0] local_addr;
      logic [PORT_W-1:0] local_port;
      logic [ADDR_W-1:0] foreign_addr;
      logic [PORT_W-1:0] foreign_port;
   } req_type;

   typedef struct packed {
      logic            found;
      logic [ID_W-1:0] match_id;
      logic [1:0]      wild_count;
      logic [1:0]      status;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]   entry_id;
      logic [ADDR_W-1:0] local_addr;
      logic [PORT_W-1:0] local_port;
      logic [ADDR_W-1:0] foreign_addr;
      logic [PORT_W-1:0] foreign_port;
   } entry_type;

   typedef struct packed {
      logic id_hit;
      logic exact_hit;
      logic wild0;
      logic wild1;
      logic wild2;
   } cell_flags_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage
`default_nettype wire

FILE: rtl/ctwl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctwl_cell: one table slot
// Holds one entry, compares it against the current item, takes a new entry
// on insert or its upper neighbor's entry when the table closes a gap.
// ----------------------------------------------------------------------------
module ctwl_cell #(
   parameter int ENTRIES = ctwl_pkg::ENTRIES_DEFAULT,
   parameter int INDEX   = 0,
   localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
   input  wire                       clock,
   input  wire ctwl_pkg::req_type    cmd,
   input  wire [CNT_W-1:0]           count,
   input  wire ctwl_pkg::cell_ctl_type ctl,
   input  wire ctwl_pkg::entry_type  upper,
   output ctwl_pkg::entry_type       entry,
   output ctwl_pkg::cell_flags_type  flags
);

   ctwl_pkg::entry_type      entry_ff, entry_in;
   ctwl_pkg::cell_flags_type flags_ff, flags_in;

   logic       live;
   logic       lz_e, lz_q, fz_e, fz_q;
   logic       skip;
   logic [1:0] wild;

   assign live = CNT_W'(INDEX) < count;

   always_comb begin
      lz_e = entry_ff.local_addr == '0;
      lz_q = cmd.local_addr == '0;
      fz_e = entry_ff.foreign_addr == '0;
      fz_q = cmd.foreign_addr == '0;
      skip = (entry_ff.local_port != cmd.local_port)
           || (!lz_e && !lz_q && entry_ff.local_addr != cmd.local_addr)
           || (!fz_e && !fz_q && (entry_ff.foreign_addr != cmd.foreign_addr
                                  || entry_ff.foreign_port != cmd.foreign_port));
      wild = {1'b0, lz_e ^ lz_q} + {1'b0, fz_e ^ fz_q};

      flags_in.id_hit    = live && entry_ff.entry_id == cmd.entry_id;
      flags_in.exact_hit = live && entry_ff.local_port == cmd.local_port
                           && entry_ff.local_addr == cmd.local_addr
                           && entry_ff.foreign_addr == cmd.foreign_addr
                           && entry_ff.foreign_port == cmd.foreign_port;
      flags_in.wild0     = live && !skip && wild == 2'd0;
      flags_in.wild1     = live && !skip && wild == 2'd1;
      flags_in.wild2     = live && !skip && wild == 2'd2;

      entry_in = entry_ff;
      if (ctl.load && count == CNT_W'(INDEX)) begin
         entry_in.entry_id     = cmd.entry_id;
         entry_in.local_addr   = cmd.local_addr;
         entry_in.local_port   = cmd.local_port;
         entry_in.foreign_addr = cmd.foreign_addr;
         entry_in.foreign_port = cmd.foreign_port;
      end else if (ctl.shift) begin
         entry_in = upper;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      flags_ff <= flags_in;
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule
`default_nettype wire

FILE: rtl/connection_table_wildcard_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// connection_table_wildcard_lookup: ordered connection table
// Insert, remove, find and exact or wildcard lookup over a row of cells.
//
//   channel  direction  payload      handshake
//   req      in         req_type     req_valid / req_ready
//   rsp      out        rsp_type     rsp_valid / rsp_ready
//
// Each item goes through a compare step that registers every cell's compare flags,
// then a select step that picks the first hit across the row and updates the cells.
// A new item is taken in the cycle the previous one finishes.
// Reset empties the table; entry contents are not cleared.
// A result waiting on rsp_ready holds the finishing step; nothing else stalls.
// ----------------------------------------------------------------------------
module connection_table_wildcard_lookup #(
   parameter int ENTRIES = ctwl_pkg::ENTRIES_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire ctwl_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output ctwl_pkg::rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(ENTRIES + 1);

   ctwl_pkg::ctl_state_type state_ff, state_in;
   ctwl_pkg::req_type       cmd_ff, cmd_in;
   ctwl_pkg::rsp_type       rsp_ff, rsp_in;
   ctwl_pkg::rsp_type       result;
   ctwl_pkg::cell_ctl_type  cctl;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   ctwl_pkg::entry_type      entries [ENTRIES];
   ctwl_pkg::cell_flags_type flags   [ENTRIES];
   logic [ENTRIES-1:0]       id_vec, ex_vec, w0_vec, w1_vec, w2_vec;
   logic [ENTRIES-1:0]       sel, first, mask;
   logic [1:0]               wsel;
   logic [ctwl_pkg::ID_W-1:0] mid;
   logic                     hit, full, finish, accept, out_free;

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         ctwl_pkg::cell_ctl_type ctl_g;
         assign ctl_g.load  = cctl.load;
         assign ctl_g.shift = cctl.shift && mask[g];
         if (g == ENTRIES - 1) begin : g_last
            ctwl_cell #(.ENTRIES(ENTRIES), .INDEX(g)) u_cell (
               .clock(clock), .cmd(cmd_ff), .count(count_ff), .ctl(ctl_g),
               .upper(entries[g]), .entry(entries[g]), .flags(flags[g])
            );
         end else begin : g_mid
            ctwl_cell #(.ENTRIES(ENTRIES), .INDEX(g)) u_cell (
               .clock(clock), .cmd(cmd_ff), .count(count_ff), .ctl(ctl_g),
               .upper(entries[g+1]), .entry(entries[g]), .flags(flags[g])
            );
         end
         assign id_vec[g] = flags[g].id_hit;
         assign ex_vec[g] = flags[g].exact_hit;
         assign w0_vec[g] = flags[g].wild0;
         assign w1_vec[g] = flags[g].wild1;
         assign w2_vec[g] = flags[g].wild2;
      end
   endgenerate

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign finish   = state_ff == ctwl_pkg::CTL_PICK && out_free;
   assign req_ready = state_ff == ctwl_pkg::CTL_IDLE || finish;
   assign accept   = req_valid && req_ready;
   assign full     = count_ff == CNT_W'(ENTRIES);

   always_comb begin
      wsel = 2'd0;
      sel  = '0;
      unique case (cmd_ff.mode)
         ctwl_pkg::MODE_REMOVE_ID,
         ctwl_pkg::MODE_FIND_ID:   sel = id_vec;
         ctwl_pkg::MODE_EXACT:     sel = ex_vec;
         ctwl_pkg::MODE_REMOVE_HD: sel = ENTRIES'(count_ff != '0);
         ctwl_pkg::MODE_WILD: begin
            if (|w0_vec) begin
               sel = w0_vec;
            end else if (|w1_vec) begin
               sel  = w1_vec;
               wsel = 2'd1;
            end else begin
               sel  = w2_vec;
               wsel = 2'd2;
            end
         end
         default: sel = '0;
      endcase
      hit   = |sel;
      first = sel & (~sel + ENTRIES'(1));
      mask  = ~(first - ENTRIES'(1));
      mid   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         mid = mid | (entries[i].entry_id & {ctwl_pkg::ID_W{first[i]}});
      end
   end

   always_comb begin
      result.found      = 1'b0;
      result.match_id   = '0;
      result.wild_count = 2'd0;
      result.status     = ctwl_pkg::ST_NOT_FOUND;
      cctl.load         = 1'b0;
      cctl.shift        = 1'b0;
      count_in          = count_ff;
      unique case (cmd_ff.mode)
         ctwl_pkg::MODE_INSERT: begin
            if (full) begin
               result.status = ctwl_pkg::ST_FULL;
            end else begin
               result.status = ctwl_pkg::ST_OK;
               cctl.load     = finish;
               count_in      = count_ff + CNT_W'(1);
            end
         end
         ctwl_pkg::MODE_REMOVE_ID,
         ctwl_pkg::MODE_REMOVE_HD: begin
            if (hit) begin
               result.found    = 1'b1;
               result.match_id = mid;
               result.status   = ctwl_pkg::ST_OK;
               cctl.shift      = finish;
               count_in        = count_ff - CNT_W'(1);
            end else if (cmd_ff.mode == ctwl_pkg::MODE_REMOVE_HD) begin
               result.status = ctwl_pkg::ST_EMPTY;
            end
         end
         ctwl_pkg::MODE_FIND_ID,
         ctwl_pkg::MODE_EXACT,
         ctwl_pkg::MODE_WILD: begin
            if (hit) begin
               result.found      = 1'b1;
               result.match_id   = mid;
               result.status     = ctwl_pkg::ST_OK;
               result.wild_count = wsel;
            end
         end
         default: result.status = ctwl_pkg::ST_NOT_FOUND;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = accept ? req_data : cmd_ff;
      rsp_in       = finish ? result : rsp_ff;
      rsp_valid_in = finish ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      unique case (state_ff)
         ctwl_pkg::CTL_IDLE: if (accept) state_in = ctwl_pkg::CTL_LOOK;
         ctwl_pkg::CTL_LOOK: state_in = ctwl_pkg::CTL_PICK;
         ctwl_pkg::CTL_PICK: begin
            if (finish) state_in = accept ? ctwl_pkg::CTL_LOOK : ctwl_pkg::CTL_IDLE;
         end
         default: state_in = ctwl_pkg::CTL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctwl_pkg::CTL_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count beyond table size");

   a_first_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(first))
      else $error("more than one cell selected");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.status == ctwl_pkg::ST_OK)
      else $error("found result without ok status");

   a_wild_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.wild_count != 2'd0 |-> rsp_data.found)
      else $error("wildcard count on a miss");

   a_pick_after_look: assert property (@(posedge clock) disable iff (reset)
      state_ff == ctwl_pkg::CTL_LOOK |=> state_ff == ctwl_pkg::CTL_PICK)
      else $error("compare step not followed by select step");

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: connection table wildcard lookup
// Random and directed table operations with a self-checking table model;
// every result is compared field by field, in order, against predictions.
// ----------------------------------------------------------------------------
module testbench;

   localparam int TABLE_DEPTH = ctwl_pkg::ENTRIES_DEFAULT;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   ctwl_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   ctwl_pkg::rsp_type rsp_data;

   connection_table_wildcard_lookup #(.ENTRIES(TABLE_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // table model
   ctwl_pkg::entry_type tbl [TABLE_DEPTH];
   int                  tbl_count;

   ctwl_pkg::req_type pending_items [$];
   ctwl_pkg::rsp_type expected_rsps [$];
   int      error_count;
   int      items_sent;
   int      rsp_seen;
   int      wild_hits;
   int      full_hits;
   bit      stim_done;
   bit      long_hold;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int id_position(logic [3:0] id);
      for (int i = 0; i < tbl_count; i++)
         if (tbl[i].entry_id == id) return i;
      return -1;
   endfunction

   function automatic void drop_entry(int pos);
      for (int i = pos; i < tbl_count - 1; i++) tbl[i] = tbl[i + 1];
      tbl_count--;
   endfunction

   function automatic ctwl_pkg::rsp_type table_apply(ctwl_pkg::req_type r);
      ctwl_pkg::rsp_type o;
      int      pos;
      int      best;
      int      w;
      bit      skip;
      o = '0;
      o.status = ctwl_pkg::ST_NOT_FOUND;
      case (r.mode)
         ctwl_pkg::MODE_INSERT: begin
            if (tbl_count >= TABLE_DEPTH) begin
               o.status = ctwl_pkg::ST_FULL;
            end else begin
               tbl[tbl_count] = {r.entry_id, r.local_addr, r.local_port,
                                 r.foreign_addr, r.foreign_port};
               tbl_count++;
               o.status = ctwl_pkg::ST_OK;
            end
         end
         ctwl_pkg::MODE_REMOVE_ID, ctwl_pkg::MODE_FIND_ID: begin
            pos = id_position(r.entry_id);
            if (pos >= 0) begin
               o.found = 1'b1;
               o.match_id = r.entry_id;
               o.status = ctwl_pkg::ST_OK;
               if (r.mode == ctwl_pkg::MODE_REMOVE_ID) drop_entry(pos);
            end
         end
         ctwl_pkg::MODE_REMOVE_HD: begin
            if (tbl_count == 0) begin
               o.status = ctwl_pkg::ST_EMPTY;
            end else begin
               o.found = 1'b1;
               o.match_id = tbl[0].entry_id;
               o.status = ctwl_pkg::ST_OK;
               drop_entry(0);
            end
         end
         ctwl_pkg::MODE_EXACT: begin
            for (int i = 0; i < tbl_count; i++) begin
               if (tbl[i].local_port == r.local_port && tbl[i].local_addr == r.local_addr &&
                   tbl[i].foreign_addr == r.foreign_addr &&
                   tbl[i].foreign_port == r.foreign_port) begin
                  o.found = 1'b1;
                  o.match_id = tbl[i].entry_id;
                  o.status = ctwl_pkg::ST_OK;
                  break;
               end
            end
         end
         ctwl_pkg::MODE_WILD: begin
            best = 3;
            pos = -1;
            for (int i = 0; i < tbl_count; i++) begin
               w = 0;
               skip = (tbl[i].local_port != r.local_port);
               if (tbl[i].local_addr != 0) begin
                  if (r.local_addr == 0) w++;
                  else if (tbl[i].local_addr != r.local_addr) skip = 1;
               end else if (r.local_addr != 0) begin
                  w++;
               end
               if (tbl[i].foreign_addr != 0) begin
                  if (r.foreign_addr == 0) w++;
                  else if (tbl[i].foreign_addr != r.foreign_addr ||
                           tbl[i].foreign_port != r.foreign_port) skip = 1;
               end else if (r.foreign_addr != 0) begin
                  w++;
               end
               if (!skip && w < best) begin
                  best = w;
                  pos = i;
                  if (w == 0) break;
               end
            end
            if (pos >= 0) begin
               o.found = 1'b1;
               o.match_id = tbl[pos].entry_id;
               o.wild_count = best[1:0];
               o.status = ctwl_pkg::ST_OK;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic int gap_length();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // small pools so lookups hit stored entries
   logic [31:0] addr_pool [4];
   logic [15:0] port_pool [4];

   function automatic logic [31:0] pick_addr();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return $urandom;
         default: return addr_pool[$urandom_range(0, 3)];
      endcase
   endfunction

   function automatic ctwl_pkg::req_type random_item();
      ctwl_pkg::req_type r;
      int      sel;
      r = '0;
      sel = $urandom_range(0, 99);
      if (sel < 30)      r.mode = ctwl_pkg::MODE_INSERT;
      else if (sel < 40) r.mode = ctwl_pkg::MODE_REMOVE_ID;
      else if (sel < 47) r.mode = ctwl_pkg::MODE_REMOVE_HD;
      else if (sel < 57) r.mode = ctwl_pkg::MODE_FIND_ID;
      else if (sel < 70) r.mode = ctwl_pkg::MODE_EXACT;
      else if (sel < 97) r.mode = ctwl_pkg::MODE_WILD;
      else               r.mode = 3'($urandom_range(6, 7));
      r.entry_id     = 4'($urandom);
      r.local_addr   = pick_addr();
      r.local_port   = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                   : port_pool[$urandom_range(0, 3)];
      r.foreign_addr = pick_addr();
      r.foreign_port = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                   : port_pool[$urandom_range(0, 3)];
      return r;
   endfunction

   function automatic ctwl_pkg::req_type make_item(logic [2:0] mode, logic [3:0] id,
                                                   logic [31:0] la, logic [15:0] lp,
                                                   logic [31:0] fa, logic [15:0] fp);
      ctwl_pkg::req_type r;
      r.mode = mode; r.entry_id = id; r.local_addr = la; r.local_port = lp;
      r.foreign_addr = fa; r.foreign_port = fp;
      return r;
   endfunction

   initial begin
      addr_pool[0] = 32'hFFFF_FFFF; addr_pool[1] = 32'h0A00_0001;
      addr_pool[2] = 32'hC0A8_0101; addr_pool[3] = 32'h0000_0001;
      port_pool[0] = 16'hFFFF; port_pool[1] = 16'd80;
      port_pool[2] = 16'd0;    port_pool[3] = 16'd443;
      // empty table cases
      pending_items.push_back(make_item(ctwl_pkg::MODE_REMOVE_HD, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(ctwl_pkg::MODE_REMOVE_ID, 4'hF, 0, 0, 0, 0));
      pending_items.push_back(make_item(ctwl_pkg::MODE_FIND_ID, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(ctwl_pkg::MODE_WILD, 0, 0, 16'd80, 0, 0));
      // wildcard ranking: two-wild, one-wild, exact, with a duplicate id
      pending_items.push_back(make_item(ctwl_pkg::MODE_INSERT, 4'd1, 0, 16'd80, 0, 16'd0));
      pending_items.push_back(make_item(ctwl_pkg::MODE_INSERT, 4'd2, 32'hC0A8_0101, 16'd80,
                                        0, 0));
      pending_items.push_back(make_item(ctwl_pkg::MODE_INSERT, 4'd3, 32'hC0A8_0101, 16'd80,
                                        32'hFFFF_FFFF, 16'hFFFF));
      pending_items.push_back(make_item(ctwl_pkg::MODE_INSERT, 4'd2, 32'hFFFF_FFFF, 16'hFFFF,
                                        32'hFFFF_FFFF, 16'hFFFF));
      pending_items.push_back(make_item(ctwl_pkg::MODE_WILD, 0, 32'hC0A8_0101, 16'd80,
                                        32'hFFFF_FFFF, 16'hFFFF));
      pending_items.push_back(make_item(ctwl_pkg::MODE_WILD, 0, 32'hC0A8_0101, 16'd80,
                                        32'hFFFF_FFFF, 16'h1234));
      pending_items.push_back(make_item(ctwl_pkg::MODE_WILD, 0, 32'h0A00_0001, 16'd80,
                                        32'h0A00_0002, 16'h1234));
      pending_items.push_back(make_item(ctwl_pkg::MODE_WILD, 0, 0, 16'd80, 0, 0));
      pending_items.push_back(make_item(ctwl_pkg::MODE_EXACT, 0, 32'hFFFF_FFFF, 16'hFFFF,
                                        32'hFFFF_FFFF, 16'hFFFF));
      pending_items.push_back(make_item(ctwl_pkg::MODE_EXACT, 0, 32'hFFFF_FFFF, 16'hFFFF,
                                        32'hFFFF_FFFF, 16'hFFFE));
      pending_items.push_back(make_item(ctwl_pkg::MODE_FIND_ID, 4'd2, 0, 0, 0, 0));
      pending_items.push_back(make_item(ctwl_pkg::MODE_REMOVE_ID, 4'd2, 0, 0, 0, 0));
      pending_items.push_back(make_item(3'd6, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 0, 0));
      pending_items.push_back(make_item(3'd7, 0, 0, 0, 32'hFFFF_FFFF, 16'hFFFF));
      pending_items.push_back(make_item(ctwl_pkg::MODE_REMOVE_HD, 0, 0, 0, 0, 0));
      // fill past capacity
      for (int i = 0; i < TABLE_DEPTH; i++)
         pending_items.push_back(make_item(ctwl_pkg::MODE_INSERT, 4'(i), $urandom, 16'd443,
                                           0, 0));
      for (int i = 0; i < 1100; i++) pending_items.push_back(random_item());
   end

   // driver
   int send_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         send_gap  <= 0;
      end else if (req_valid && !req_ready) begin
         // hold the offered item
      end else begin
         if (req_valid) items_sent <= items_sent + 1;
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_items.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_items.pop_front();
            send_gap  <= gap_length();
         end else begin
            req_valid <= 1'b0;
            stim_done <= 1'b1;
         end
      end
   end

   // predict on acceptance
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         if (req_data.mode == ctwl_pkg::MODE_INSERT && tbl_count >= TABLE_DEPTH) full_hits++;
         expected_rsps.push_back(table_apply(req_data));
      end
   end

   // receiver stalls: one long hold-off early, then random gaps
   int stall_left;
   int hold_cycles;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_left  <= 0;
         hold_cycles <= 0;
         long_hold   <= 1'b0;
      end else if (!long_hold && items_sent >= 22) begin
         rsp_ready <= 1'b0;
         if (hold_cycles == 60) long_hold <= 1'b1;
         hold_cycles <= hold_cycles + 1;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= gap_length();
      end
   end

   // monitor
   ctwl_pkg::rsp_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (expected_rsps.size() == 0) begin
            $error("result with no item outstanding: %p", rsp_data);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (want.found && want.wild_count != 0) wild_hits++;
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0d actual %0d", want.found, rsp_data.found);
               error_count++;
            end
            if (rsp_data.match_id !== want.match_id) begin
               $error("match_id: expected %0d actual %0d", want.match_id, rsp_data.match_id);
               error_count++;
            end
            if (rsp_data.wild_count !== want.wild_count) begin
               $error("wild_count: expected %0d actual %0d", want.wild_count,
                      rsp_data.wild_count);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      tbl_count = 0;
      error_count = 0;
      items_sent = 0;
      rsp_seen = 0;
      wild_hits = 0;
      full_hits = 0;
      stim_done = 1'b0;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && expected_rsps.size() == 0);
      repeat (20) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d results never arrived", expected_rsps.size());
         error_count++;
      end
      $display("covered %0d items, %0d results, %0d wildcard matches, %0d inserts into a full table",
               items_sent, rsp_seen, wild_hits, full_hits);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout waiting for results");
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
